[sv/csrmv_pkg.sv]
`timescale 1ns / 1ps
package csrmv_pkg;

  localparam int MAX_NONZEROS = 1024;
  localparam int MAX_ROWS     = 64;
  localparam int MAX_COLUMNS  = 1024;

  localparam int OP_W    = 2;
  localparam int SLOT_W  = 10;
  localparam int DATA_W  = 32;
  localparam int COL_W   = 10;
  localparam int PTR_W   = 11;
  localparam int ROWS_W  = 7;
  localparam int COLS_W  = 11;
  localparam int ROW_W   = 6;
  localparam int CFG_W   = 11;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int FRAC_W  = 16;

  // 1024 products of at most 2^62 each need 74 bits; two spare bits on top.
  localparam int ACC_W   = 76;
  localparam int SUM_TOP = DATA_W + FRAC_W - 1;

  localparam int NZ_AW   = $clog2(MAX_NONZEROS);
  localparam int RS_AW   = $clog2(MAX_ROWS + 1);
  localparam int X_AW    = $clog2(MAX_COLUMNS);
  localparam int ENTRY_W = COL_W + DATA_W;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE_NONZERO   = 2'd0,
    OP_WRITE_ROW_START = 2'd1,
    OP_WRITE_X         = 2'd2,
    OP_RUN             = 2'd3
  } op_t;

  typedef enum logic {
    REG_ROW_COUNT    = 1'b0,
    REG_COLUMN_COUNT = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_FIRST_WAIT,
    ST_NEXT,
    ST_END_WAIT,
    ST_WALK,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic run_init;
    logic ptr_first;
    logic base_load;
    logic row_init;
    logic issue;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic rows_zero;
    logic walk_more;
    logic pipe_idle;
    logic last;
  } status_t;

  function automatic logic [PTR_W-1:0] clamp_ptr(input logic [PTR_W-1:0] p);
    if (p > PTR_W'(MAX_NONZEROS)) begin
      return PTR_W'(MAX_NONZEROS);
    end
    return p;
  endfunction

endpackage

[sv/csrmv_ram.sv]
`timescale 1ns / 1ps
module csrmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/csrmv_ctrl.sv]
`timescale 1ns / 1ps
module csrmv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                run_req,
  input  csrmv_pkg::status_t  status,
  output csrmv_pkg::cmd_t     cmd,
  output logic                busy
);

  csrmv_pkg::state_t state;
  csrmv_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csrmv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      csrmv_pkg::ST_IDLE: begin
        if (run_req && !status.rows_zero) begin
          state_next = csrmv_pkg::ST_FIRST;
        end
      end
      csrmv_pkg::ST_FIRST:      state_next = csrmv_pkg::ST_FIRST_WAIT;
      csrmv_pkg::ST_FIRST_WAIT: state_next = csrmv_pkg::ST_END_WAIT;
      csrmv_pkg::ST_NEXT:       state_next = csrmv_pkg::ST_END_WAIT;
      csrmv_pkg::ST_END_WAIT:   state_next = csrmv_pkg::ST_WALK;
      csrmv_pkg::ST_WALK: begin
        if (!status.walk_more) begin
          state_next = csrmv_pkg::ST_DRAIN;
        end
      end
      csrmv_pkg::ST_DRAIN: begin
        if (status.pipe_idle) begin
          state_next = csrmv_pkg::ST_EMIT;
        end
      end
      csrmv_pkg::ST_EMIT: begin
        state_next = status.last ? csrmv_pkg::ST_IDLE : csrmv_pkg::ST_NEXT;
      end
      default: state_next = csrmv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    busy          = (state != csrmv_pkg::ST_IDLE);
    cmd.run_init  = (state == csrmv_pkg::ST_IDLE) && run_req;
    cmd.ptr_first = (state == csrmv_pkg::ST_FIRST);
    cmd.base_load = (state == csrmv_pkg::ST_FIRST_WAIT);
    cmd.row_init  = (state == csrmv_pkg::ST_END_WAIT);
    cmd.issue     = (state == csrmv_pkg::ST_WALK) && status.walk_more;
    cmd.emit      = (state == csrmv_pkg::ST_EMIT);
  end

endmodule

[sv/csrmv_dpath.sv]
`timescale 1ns / 1ps
module csrmv_dpath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 accept,
  input  logic [csrmv_pkg::OP_W-1:0]           operation,
  input  logic [csrmv_pkg::SLOT_W-1:0]         slot,
  input  logic signed [csrmv_pkg::DATA_W-1:0]  number,
  input  logic [csrmv_pkg::COL_W-1:0]          column_index,
  input  logic [csrmv_pkg::PTR_W-1:0]          row_pointer,
  input  logic                                 cfg_write,
  input  logic                                 cfg_index,
  input  logic [csrmv_pkg::CFG_W-1:0]          cfg_data,
  input  csrmv_pkg::cmd_t                      cmd,
  output csrmv_pkg::status_t                   status,
  output logic                                 result_valid,
  output logic [csrmv_pkg::ROW_W-1:0]          row_number,
  output logic signed [csrmv_pkg::DATA_W-1:0]  row_sum,
  output logic                                 saturated,
  output logic                                 bad_column,
  output logic                                 last_row
);

  logic [csrmv_pkg::ROWS_W-1:0]  row_count;
  logic [csrmv_pkg::COLS_W-1:0]  column_count;
  logic [csrmv_pkg::ROWS_W-1:0]  rows_lim;
  logic [csrmv_pkg::COLS_W-1:0]  cols_lim;
  logic [csrmv_pkg::ROW_W-1:0]   row;
  logic [csrmv_pkg::PTR_W-1:0]   base;
  logic [csrmv_pkg::PTR_W-1:0]   end_ptr;
  logic [csrmv_pkg::PTR_W-1:0]   walk;
  logic                          is_last;

  logic                          nz_we, rs_we, x_we;
  logic [csrmv_pkg::ENTRY_W-1:0] entry_rd;
  logic [csrmv_pkg::PTR_W-1:0]   rs_rd;
  logic [csrmv_pkg::RS_AW-1:0]   rs_raddr;
  logic [csrmv_pkg::DATA_W-1:0]  x_rd;
  logic [csrmv_pkg::DATA_W-1:0]  e_value;
  logic [csrmv_pkg::COL_W-1:0]   e_col;
  logic                          good;

  logic                          s1_valid, s2_valid, s3_valid;
  logic [csrmv_pkg::DATA_W-1:0]  s2_value;
  logic signed [csrmv_pkg::PROD_W-1:0] product;
  logic [csrmv_pkg::ACC_W-1:0]   acc;
  logic                          bad;
  logic                          fits;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= csrmv_pkg::ROWS_W'(1);
      column_count <= csrmv_pkg::COLS_W'(1);
    end else if (cfg_write) begin
      if (cfg_index == csrmv_pkg::REG_ROW_COUNT) begin
        row_count <= cfg_data[csrmv_pkg::ROWS_W-1:0];
      end else begin
        column_count <= cfg_data[csrmv_pkg::COLS_W-1:0];
      end
    end
  end

  assign rows_lim = (row_count > csrmv_pkg::ROWS_W'(csrmv_pkg::MAX_ROWS))
                  ? csrmv_pkg::ROWS_W'(csrmv_pkg::MAX_ROWS) : row_count;
  assign cols_lim = (column_count > csrmv_pkg::COLS_W'(csrmv_pkg::MAX_COLUMNS))
                  ? csrmv_pkg::COLS_W'(csrmv_pkg::MAX_COLUMNS) : column_count;
  assign is_last  = (csrmv_pkg::ROWS_W'(row) + csrmv_pkg::ROWS_W'(1)) == rows_lim;

  // Loads go straight into the stores; slot always fits the nonzero and x stores.
  assign nz_we = accept && (operation == csrmv_pkg::OP_WRITE_NONZERO);
  assign x_we  = accept && (operation == csrmv_pkg::OP_WRITE_X);
  assign rs_we = accept && (operation == csrmv_pkg::OP_WRITE_ROW_START)
              && (slot <= csrmv_pkg::SLOT_W'(csrmv_pkg::MAX_ROWS));

  assign rs_raddr = cmd.ptr_first ? '0
                  : csrmv_pkg::RS_AW'(row) + csrmv_pkg::RS_AW'(1);

  csrmv_ram #(
    .WIDTH (csrmv_pkg::ENTRY_W),
    .DEPTH (csrmv_pkg::MAX_NONZEROS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (nz_we),
    .waddr (slot[csrmv_pkg::NZ_AW-1:0]),
    .wdata ({column_index, number}),
    .raddr (walk[csrmv_pkg::NZ_AW-1:0]),
    .rdata (entry_rd)
  );

  csrmv_ram #(
    .WIDTH (csrmv_pkg::PTR_W),
    .DEPTH (csrmv_pkg::MAX_ROWS + 1)
  ) u_row_start_ram (
    .clk   (clk),
    .we    (rs_we),
    .waddr (slot[csrmv_pkg::RS_AW-1:0]),
    .wdata (row_pointer),
    .raddr (rs_raddr),
    .rdata (rs_rd)
  );

  assign e_value = entry_rd[csrmv_pkg::DATA_W-1:0];
  assign e_col   = entry_rd[csrmv_pkg::ENTRY_W-1:csrmv_pkg::DATA_W];
  assign good    = csrmv_pkg::COLS_W'(e_col) < cols_lim;

  csrmv_ram #(
    .WIDTH (csrmv_pkg::DATA_W),
    .DEPTH (csrmv_pkg::MAX_COLUMNS)
  ) u_x_ram (
    .clk   (clk),
    .we    (x_we),
    .waddr (slot[csrmv_pkg::X_AW-1:0]),
    .wdata (number),
    .raddr (e_col[csrmv_pkg::X_AW-1:0]),
    .rdata (x_rd)
  );

  // The end pointer of one row is the start pointer of the next.
  always_ff @(posedge clk) begin
    if (cmd.base_load) begin
      base <= csrmv_pkg::clamp_ptr(rs_rd);
    end else if (cmd.emit) begin
      base <= end_ptr;
    end
    if (cmd.row_init) begin
      end_ptr <= csrmv_pkg::clamp_ptr(rs_rd);
      walk    <= base;
    end else if (cmd.issue) begin
      walk <= walk + csrmv_pkg::PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (cmd.run_init) begin
      row <= '0;
    end else if (cmd.emit) begin
      row <= row + csrmv_pkg::ROW_W'(1);
    end
  end

  // Pipeline: entry read, x read and column check, multiply, accumulate.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      bad      <= 1'b0;
      acc      <= '0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid && good;
      s3_valid <= s2_valid;
      if (cmd.row_init) begin
        bad <= 1'b0;
        acc <= '0;
      end else begin
        if (s1_valid && !good) begin
          bad <= 1'b1;
        end
        if (s3_valid) begin
          acc <= acc + {{(csrmv_pkg::ACC_W - csrmv_pkg::PROD_W){product[csrmv_pkg::PROD_W-1]}},
                        product};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    s2_value <= e_value;
    product  <= $signed(s2_value) * $signed(x_rd);
  end

  assign status.rows_zero = (row_count == '0);
  assign status.walk_more = (walk < end_ptr);
  assign status.pipe_idle = !s1_valid && !s2_valid && !s3_valid;
  assign status.last      = is_last;

  // The sum fits Q16.16 when every bit from bit 47 up equals the sign.
  assign fits = (acc[csrmv_pkg::ACC_W-1:csrmv_pkg::SUM_TOP]
              == {(csrmv_pkg::ACC_W - csrmv_pkg::SUM_TOP){acc[csrmv_pkg::ACC_W-1]}});

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      row_number <= row;
      saturated  <= !fits;
      bad_column <= bad;
      last_row   <= is_last;
      if (fits) begin
        row_sum <= acc[csrmv_pkg::SUM_TOP:csrmv_pkg::FRAC_W];
      end else if (acc[csrmv_pkg::ACC_W-1]) begin
        row_sum <= {1'b1, {(csrmv_pkg::DATA_W-1){1'b0}}};
      end else begin
        row_sum <= {1'b0, {(csrmv_pkg::DATA_W-1){1'b1}}};
      end
    end
  end

endmodule

[sv/csr_sparse_matrix_vector_multiply_core.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake                 Payload
// command   in         start / busy              operation, slot, number,
//                                                column_index, row_pointer
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
// result    out        result_valid (strobe)     row_number, row_sum, saturated,
//                                                bad_column, last_row
//
// Load commands are taken whenever busy is low and keep busy low.
// A run handles one row after another; the first row also reads its start pointer,
// each row drains the pipe before its result; the entry store's single read port
// walks one nonzero per cycle through a four-stage multiply pipe.
// Reset is synchronous; the stores are not cleared and must be written before use.
// The result side cannot stall; each result is shown for one cycle.
module csr_sparse_matrix_vector_multiply_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [csrmv_pkg::OP_W-1:0]           operation,
  input  logic [csrmv_pkg::SLOT_W-1:0]         slot,
  input  logic signed [csrmv_pkg::DATA_W-1:0]  number,
  input  logic [csrmv_pkg::COL_W-1:0]          column_index,
  input  logic [csrmv_pkg::PTR_W-1:0]          row_pointer,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic                                 cfg_index,
  input  logic [csrmv_pkg::CFG_W-1:0]          cfg_data,
  output logic                                 result_valid,
  output logic [csrmv_pkg::ROW_W-1:0]          row_number,
  output logic signed [csrmv_pkg::DATA_W-1:0]  row_sum,
  output logic                                 saturated,
  output logic                                 bad_column,
  output logic                                 last_row
);

  logic               accept;
  logic               run_req;
  csrmv_pkg::cmd_t    cmd;
  csrmv_pkg::status_t status;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign run_req   = accept && (operation == csrmv_pkg::OP_RUN);

  csrmv_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .run_req (run_req),
    .status  (status),
    .cmd     (cmd),
    .busy    (busy)
  );

  csrmv_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .operation    (operation),
    .slot         (slot),
    .number       (number),
    .column_index (column_index),
    .row_pointer  (row_pointer),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .row_number   (row_number),
    .row_sum      (row_sum),
    .saturated    (saturated),
    .bad_column   (bad_column),
    .last_row     (last_row)
  );

  // Results only come out of a run that was in progress in the previous cycle.
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result strobe outside a run");

  // The final row of a run leaves the block idle.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_row) |-> !busy)
    else $error("block still busy after the final row");

  // An emit state is never followed by another emit, so strobes never come back to back.
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("two results in consecutive cycles");

endmodule

[verif/tb_csr_sparse_matrix_vector_multiply_core.sv]
`timescale 1ns / 1ps
module tb_csr_sparse_matrix_vector_multiply_core;
  import csrmv_pkg::*;

  typedef struct packed {
    logic [ROW_W-1:0]  row_number;
    logic [DATA_W-1:0] row_sum;
    logic              saturated;
    logic              bad_column;
    logic              last_row;
  } row_result_t;

  // Keeps a copy of the matrix, the x vector and the dimensions, and turns every
  // accepted run into the row results that it must produce.
  class row_sum_scoreboard;
    logic signed [DATA_W-1:0] entry_value [MAX_NONZEROS];
    logic [COL_W-1:0]         entry_column [MAX_NONZEROS];
    logic [PTR_W-1:0]         row_start [MAX_ROWS+1];
    logic signed [DATA_W-1:0] x_value [MAX_COLUMNS];
    logic [ROWS_W-1:0]        row_count;
    logic [COLS_W-1:0]        column_count;
    row_result_t              expected_rows [$];
    int                       mismatches;

    function new();
      row_count    = 1;
      column_count = 1;
      mismatches   = 0;
    endfunction

    function int unsigned limit_pointer(logic [PTR_W-1:0] p);
      return (p > MAX_NONZEROS) ? MAX_NONZEROS : int'(p);
    endfunction

    task report_mismatch(string text);
      $display("[%0t] mismatch: %s", $realtime, text);
      mismatches++;
    endtask

    task write_register(logic idx, logic [CFG_W-1:0] data);
      if (idx == REG_ROW_COUNT) begin
        row_count = data[ROWS_W-1:0];
      end else begin
        column_count = data[COLS_W-1:0];
      end
    endtask

    task predict_rows();
      int unsigned rows_used, col_limit, first, stop;
      logic signed [127:0] acc;
      logic signed [63:0]  prod;
      logic                flagged;
      row_result_t         want;
      rows_used = (row_count > MAX_ROWS) ? MAX_ROWS : row_count;
      col_limit = (column_count > MAX_COLUMNS) ? MAX_COLUMNS : column_count;
      for (int i = 0; i < rows_used; i++) begin
        first   = limit_pointer(row_start[i]);
        stop    = limit_pointer(row_start[i+1]);
        acc     = '0;
        flagged = 1'b0;
        for (int unsigned j = first; j < stop; j++) begin
          if (entry_column[j] >= col_limit) begin
            flagged = 1'b1;
          end else begin
            prod = entry_value[j] * x_value[entry_column[j]];
            acc  = acc + prod;
          end
        end
        want.row_number = ROW_W'(i);
        want.bad_column = flagged;
        want.last_row   = (i + 1 == rows_used);
        // The Q32.32 sum fits Q16.16 after the floor shift only inside +/- 2^47.
        if ((acc >>> 47) == 0 || (acc >>> 47) == -1) begin
          want.saturated = 1'b0;
          want.row_sum   = acc[DATA_W+FRAC_W-1:FRAC_W];
        end else begin
          want.saturated = 1'b1;
          want.row_sum   = acc[127] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        expected_rows.push_back(want);
      end
    endtask

    task note_command(op_t op, logic [SLOT_W-1:0] s, logic [DATA_W-1:0] n,
                      logic [COL_W-1:0] c, logic [PTR_W-1:0] p);
      case (op)
        OP_WRITE_NONZERO: begin
          entry_value[s]  = n;
          entry_column[s] = c;
        end
        OP_WRITE_ROW_START: begin
          if (s <= MAX_ROWS) row_start[s] = p;
        end
        OP_WRITE_X: begin
          x_value[s] = n;
        end
        default: begin
          predict_rows();
        end
      endcase
    endtask

    task check_result(row_result_t got);
      row_result_t want;
      string       diffs;
      if (expected_rows.size() == 0) begin
        report_mismatch($sformatf("result for row %0d with no run transaction waiting",
                                  got.row_number));
        return;
      end
      want  = expected_rows.pop_front();
      diffs = "";
      if (got.row_number !== want.row_number)
        diffs = {diffs, $sformatf(" row_number %0d/%0d", got.row_number, want.row_number)};
      if (got.row_sum !== want.row_sum)
        diffs = {diffs, $sformatf(" row_sum %h/%h", got.row_sum, want.row_sum)};
      if (got.saturated !== want.saturated)
        diffs = {diffs, $sformatf(" saturated %b/%b", got.saturated, want.saturated)};
      if (got.bad_column !== want.bad_column)
        diffs = {diffs, $sformatf(" bad_column %b/%b", got.bad_column, want.bad_column)};
      if (got.last_row !== want.last_row)
        diffs = {diffs, $sformatf(" last_row %b/%b", got.last_row, want.last_row)};
      if (diffs != "")
        report_mismatch($sformatf("row %0d, got/expected:%s", want.row_number, diffs));
    endtask

    task finish_check();
      if (expected_rows.size() != 0)
        report_mismatch($sformatf("%0d row results never arrived", expected_rows.size()));
    endtask
  endclass

  logic                     clk;
  logic                     rst;
  logic                     start;
  logic                     busy;
  logic [OP_W-1:0]          operation;
  logic [SLOT_W-1:0]        slot;
  logic signed [DATA_W-1:0] number;
  logic [COL_W-1:0]         column_index;
  logic [PTR_W-1:0]         row_pointer;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic                     cfg_index;
  logic [CFG_W-1:0]         cfg_data;
  logic                     result_valid;
  logic [ROW_W-1:0]         row_number;
  logic signed [DATA_W-1:0] row_sum;
  logic                     saturated;
  logic                     bad_column;
  logic                     last_row;

  localparam int RANDOM_ITEMS = 340;
  localparam int SETTLE_CYCLES = 32;

  row_sum_scoreboard sb = new();

  // What the stimulus side has written so far, so that a run never reads an
  // entry that was never loaded.
  bit          gen_nz_ok [MAX_NONZEROS];
  int unsigned gen_col [MAX_NONZEROS];
  bit          gen_rs_ok [MAX_ROWS+1];
  int unsigned gen_rs [MAX_ROWS+1];
  bit          gen_x_ok [MAX_COLUMNS];
  int unsigned gen_rows = 1;
  int unsigned gen_cols = 1;
  int          sender_idle_pct = 0;
  int          item_count = 0;

  csr_sparse_matrix_vector_multiply_core dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .slot         (slot),
    .number       (number),
    .column_index (column_index),
    .row_pointer  (row_pointer),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .result_valid (result_valid),
    .row_number   (row_number),
    .row_sum      (row_sum),
    .saturated    (saturated),
    .bad_column   (bad_column),
    .last_row     (last_row)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Signals are sampled right after the edge, before any nonblocking update.
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy)
        sb.note_command(op_t'(operation), slot, number, column_index, row_pointer);
      if (cfg_valid && cfg_ready)
        sb.write_register(cfg_index, cfg_data);
      if (result_valid)
        sb.check_result('{row_number, row_sum, saturated, bad_column, last_row});
    end
  end

  function automatic int unsigned rows_in_use();
    return (gen_rows > MAX_ROWS) ? MAX_ROWS : gen_rows;
  endfunction

  function automatic int unsigned cols_in_use();
    return (gen_cols > MAX_COLUMNS) ? MAX_COLUMNS : gen_cols;
  endfunction

  function automatic logic [DATA_W-1:0] rand_number();
    logic [DATA_W-1:0] magnitude;
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0001_0000;
      3: return 32'hFFFF_FFFF;
      4, 5, 6: begin
        magnitude = $urandom_range(0, 32'h000F_FFFF);
        return $urandom_range(0, 1) ? -magnitude : magnitude;
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic int unsigned pick_column(int unsigned cols_eff);
    if (cols_eff == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return $urandom_range(0, cols_eff - 1);
  endfunction

  task automatic send_command(op_t op, int unsigned slot_v, logic [DATA_W-1:0] num_v,
                              int unsigned col_v, int unsigned ptr_v);
    int unsigned gap;
    if (sender_idle_pct != 0 && $urandom_range(0, 99) < sender_idle_pct) begin
      gap = $urandom_range(1, 4);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    operation    <= op;
    slot         <= SLOT_W'(slot_v);
    number       <= num_v;
    column_index <= COL_W'(col_v);
    row_pointer  <= PTR_W'(ptr_v);
    do @(posedge clk); while (busy);
    item_count++;
    case (op)
      OP_WRITE_NONZERO: begin
        gen_nz_ok[SLOT_W'(slot_v)] = 1'b1;
        gen_col[SLOT_W'(slot_v)]   = COL_W'(col_v);
      end
      OP_WRITE_ROW_START: begin
        if (SLOT_W'(slot_v) <= MAX_ROWS) begin
          gen_rs_ok[SLOT_W'(slot_v)] = 1'b1;
          gen_rs[SLOT_W'(slot_v)]    = PTR_W'(ptr_v);
        end
      end
      OP_WRITE_X: gen_x_ok[SLOT_W'(slot_v)] = 1'b1;
      default: ;
    endcase
  endtask

  task automatic set_dimensions(logic [CFG_W-1:0] rows_data, logic [CFG_W-1:0] cols_data);
    cfg_valid <= 1'b1;
    cfg_index <= REG_ROW_COUNT;
    cfg_data  <= rows_data;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_COLUMN_COUNT;
    cfg_data  <= cols_data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    gen_rows = rows_data[ROWS_W-1:0];
    gen_cols = cols_data;
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    @(posedge clk);
    while (sb.expected_rows.size() != 0 || busy) @(posedge clk);
    // A run with no rows leaves nothing to wait for, so give it time to finish.
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Loads whatever the next run would read but was never written.
  task automatic make_reads_defined();
    int unsigned rows_eff, cols_eff, first, stop;
    rows_eff = rows_in_use();
    cols_eff = cols_in_use();
    if (rows_eff == 0) return;
    for (int i = 0; i <= rows_eff; i++) begin
      if (!gen_rs_ok[i]) send_command(OP_WRITE_ROW_START, i, rand_number(), $urandom(), 0);
    end
    for (int i = 0; i < rows_eff; i++) begin
      first = sb.limit_pointer(PTR_W'(gen_rs[i]));
      stop  = sb.limit_pointer(PTR_W'(gen_rs[i+1]));
      for (int unsigned j = first; j < stop; j++) begin
        if (!gen_nz_ok[j])
          send_command(OP_WRITE_NONZERO, j, rand_number(), pick_column(cols_eff), $urandom());
        if (gen_col[j] < cols_eff && !gen_x_ok[gen_col[j]])
          send_command(OP_WRITE_X, gen_col[j], rand_number(), $urandom(), $urandom());
      end
    end
  endtask

  task automatic run_multiply();
    make_reads_defined();
    send_command(OP_RUN, $urandom(), rand_number(), $urandom(), $urandom());
  endtask

  task automatic load_and_run(logic [CFG_W-1:0] rows_data, logic [CFG_W-1:0] cols_data);
    int unsigned rows_eff, cols_eff, total, base, pick;
    int unsigned ptrs [MAX_ROWS+1];
    int unsigned per_row [MAX_ROWS];
    wait_for_quiet();
    set_dimensions(rows_data, cols_data);
    rows_eff = rows_in_use();
    cols_eff = cols_in_use();
    repeat ($urandom_range(0, 3)) begin
      send_command(op_t'($urandom_range(0, 2)), $urandom(), rand_number(), $urandom(),
                   $urandom());
    end
    if (rows_eff == 0) begin
      run_multiply();
      return;
    end
    total = 0;
    for (int i = 0; i < rows_eff; i++) begin
      per_row[i] = (rows_eff > 8) ? $urandom_range(0, 1) : $urandom_range(0, 4);
      total += per_row[i];
    end
    if ($urandom_range(0, 3) == 0) base = MAX_NONZEROS - total;
    else base = $urandom_range(0, MAX_NONZEROS - total);
    ptrs[0] = base;
    for (int i = 0; i < rows_eff; i++) ptrs[i+1] = ptrs[i] + per_row[i];
    if (ptrs[rows_eff] == MAX_NONZEROS && $urandom_range(0, 1))
      ptrs[rows_eff] = MAX_NONZEROS + $urandom_range(0, 1023);
    // Pulling a pointer back shortens or empties one row and lets the next overlap.
    for (int i = 1; i < rows_eff; i++) begin
      if ($urandom_range(0, 9) == 0) ptrs[i] = $urandom_range(base, ptrs[i]);
    end
    for (int i = 0; i <= rows_eff; i++)
      send_command(OP_WRITE_ROW_START, i, rand_number(), $urandom(), ptrs[i]);
    for (int unsigned j = base; j < base + total; j++)
      send_command(OP_WRITE_NONZERO, j, rand_number(), pick_column(cols_eff), $urandom());
    for (int unsigned j = base; j < base + total; j++) begin
      if (gen_col[j] < cols_eff && $urandom_range(0, 9) < 6)
        send_command(OP_WRITE_X, gen_col[j], rand_number(), $urandom(), $urandom());
    end
    run_multiply();
    if ($urandom_range(0, 9) < 4) begin
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 2);
        if (pick == 0 && total != 0)
          send_command(OP_WRITE_NONZERO, $urandom_range(base, base + total - 1), rand_number(),
                       pick_column(cols_eff), $urandom());
        else if (pick == 1 && cols_eff != 0)
          send_command(OP_WRITE_X, $urandom_range(0, cols_eff - 1), rand_number(), $urandom(),
                       $urandom());
        else
          send_command(OP_WRITE_ROW_START, $urandom_range(0, rows_eff), rand_number(),
                       $urandom(), $urandom_range(base, base + total));
      end
      run_multiply();
    end
  endtask

  function automatic logic [CFG_W-1:0] random_rows();
    int unsigned r;
    case ($urandom_range(0, 19))
      0: r = 0;
      1: r = 1;
      2: r = 64;
      3: r = $urandom_range(65, 127);
      default: r = $urandom_range(2, 6);
    endcase
    // Bits above the register width are written too and must be dropped.
    return CFG_W'(r | ($urandom_range(0, 15) << ROWS_W));
  endfunction

  function automatic logic [CFG_W-1:0] random_cols();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 1;
      2: return 1024;
      3: return $urandom_range(1025, 2047);
      default: return $urandom_range(2, 12);
    endcase
  endfunction

  initial begin
    int directed_items;
    rst          <= 1'b1;
    start        <= 1'b0;
    operation    <= OP_WRITE_NONZERO;
    slot         <= '0;
    number       <= '0;
    column_index <= '0;
    row_pointer  <= '0;
    cfg_valid    <= 1'b0;
    cfg_index    <= REG_ROW_COUNT;
    cfg_data     <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Four rows over four columns: row 0 ends past the store and saturates low,
    // row 1 ends before it starts, row 2 saturates high with a bad column, and
    // row 3 starts where it ends.
    set_dimensions(4, 4);
    send_command(OP_WRITE_ROW_START, 0, 0, 0, 1021);
    send_command(OP_WRITE_ROW_START, 1, 0, 0, 2047);
    send_command(OP_WRITE_ROW_START, 2, 0, 0, 0);
    send_command(OP_WRITE_ROW_START, 3, 0, 0, 3);
    send_command(OP_WRITE_ROW_START, 4, 0, 0, 3);
    send_command(OP_WRITE_ROW_START, 1023, 0, 0, 0);
    send_command(OP_WRITE_NONZERO, 0, 32'h7FFF_FFFF, 0, 0);
    send_command(OP_WRITE_NONZERO, 1, 32'h7FFF_FFFF, 1, 0);
    send_command(OP_WRITE_NONZERO, 2, 32'h0001_0000, 1023, 0);
    send_command(OP_WRITE_NONZERO, 1021, 32'h8000_0000, 3, 0);
    send_command(OP_WRITE_NONZERO, 1022, 32'h8000_0000, 3, 0);
    send_command(OP_WRITE_NONZERO, 1023, 32'hFFFF_FFFF, 2, 0);
    send_command(OP_WRITE_X, 0, 32'h7FFF_FFFF, 0, 0);
    send_command(OP_WRITE_X, 1, 32'h7FFF_FFFF, 0, 0);
    send_command(OP_WRITE_X, 2, 32'h8000_0000, 0, 0);
    send_command(OP_WRITE_X, 3, 32'h7FFF_FFFF, 0, 0);
    send_command(OP_WRITE_X, 1023, 32'hFFFF_FFFF, 0, 0);
    run_multiply();
    // Small values in row 0 so that it lands in range.
    send_command(OP_WRITE_NONZERO, 1021, 32'hFFFE_0000, 3, 0);
    send_command(OP_WRITE_NONZERO, 1022, 32'h0001_8000, 3, 0);
    send_command(OP_WRITE_X, 3, 32'hFFFF_8000, 0, 0);
    run_multiply();
    directed_items = item_count;

    for (int p = 0; p < 4; p++) begin
      case (p)
        1:       sender_idle_pct = 47;
        3:       sender_idle_pct = 6;
        default: sender_idle_pct = 0;
      endcase
      case (p)
        0: load_and_run(11'h781, 1);
        1: load_and_run(127, 2047);
        2: load_and_run(0, 0);
        default: load_and_run(64, 1024);
      endcase
      while (item_count < directed_items + RANDOM_ITEMS * (p + 1) / 4)
        load_and_run(random_rows(), random_cols());
    end

    wait_for_quiet();
    sb.finish_check();
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
